// ===== sv/mp2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2d_pkg : shared types and constants for the 2-D max pooling block
// Register indexes, operation codes, controller states and the command,
// status and configuration structs passed between the submodules.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    // input coordinate fields
    localparam int COORD_BITS = 6;
    // signed tap coordinate: row*stride - pad + kernel offset
    localparam int TAP_BITS   = 12;

    // configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_HEIGHT  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_WIDTH   = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_HEIGHT = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_ROWS   = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_COLS   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAD_TOP       = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAD_LEFT      = 4'd7;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic [6:0] plane_height;
        logic [6:0] plane_width;
        logic [3:0] kernel_height;
        logic [3:0] kernel_width;
        logic [3:0] stride_rows;
        logic [3:0] stride_cols;
        logic [2:0] pad_top;
        logic [2:0] pad_left;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;     // write the input sample into the plane store
        logic capture;  // latch window origin and clear the running max
        logic issue;    // read the current tap and advance the tap counters
    } t_cmd;

    typedef struct packed {
        logic last_tap; // current tap is the last of the window
    } t_status;

endpackage

// ===== sv/mp2d_cfg.sv =====
// ----------------------------------------------------------------------------
// mp2d_cfg : configuration register file
// Eight registers written through a valid/ready channel; indexes past the
// list are accepted and dropped.
// ----------------------------------------------------------------------------
module mp2d_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mp2d_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output mp2d_pkg::t_cfg                      o_cfg
);

    mp2d_pkg::t_cfg r_cfg;
    mp2d_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mp2d_pkg::REG_PLANE_HEIGHT:  n_cfg.plane_height  = i_cfg_data;
                mp2d_pkg::REG_PLANE_WIDTH:   n_cfg.plane_width   = i_cfg_data;
                mp2d_pkg::REG_KERNEL_HEIGHT: n_cfg.kernel_height = i_cfg_data[3:0];
                mp2d_pkg::REG_KERNEL_WIDTH:  n_cfg.kernel_width  = i_cfg_data[3:0];
                mp2d_pkg::REG_STRIDE_ROWS:   n_cfg.stride_rows   = i_cfg_data[3:0];
                mp2d_pkg::REG_STRIDE_COLS:   n_cfg.stride_cols   = i_cfg_data[3:0];
                mp2d_pkg::REG_PAD_TOP:       n_cfg.pad_top       = i_cfg_data[2:0];
                mp2d_pkg::REG_PAD_LEFT:      n_cfg.pad_left      = i_cfg_data[2:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_height  <= 7'd1;
            r_cfg.plane_width   <= 7'd1;
            r_cfg.kernel_height <= 4'd1;
            r_cfg.kernel_width  <= 4'd1;
            r_cfg.stride_rows   <= 4'd1;
            r_cfg.stride_cols   <= 4'd1;
            r_cfg.pad_top       <= 3'd0;
            r_cfg.pad_left      <= 3'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/mp2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// mp2d_ctrl : sequencing state machine
// Takes items, walks the window one tap a cycle, drains the read pipe and
// strobes the result.
// ----------------------------------------------------------------------------
module mp2d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  mp2d_pkg::t_status i_status,
    output mp2d_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_result_valid
);

    mp2d_pkg::t_state r_state;
    mp2d_pkg::t_state n_state;
    logic             accept;

    assign o_busy = (r_state == mp2d_pkg::S_WALK) || (r_state == mp2d_pkg::S_DRAIN);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mp2d_pkg::S_IDLE, mp2d_pkg::S_DONE: begin
                if (accept && (i_operation == mp2d_pkg::OP_COMPUTE)) begin
                    n_state = mp2d_pkg::S_WALK;
                end else begin
                    n_state = mp2d_pkg::S_IDLE;
                end
            end
            mp2d_pkg::S_WALK: begin
                if (i_status.last_tap) begin
                    n_state = mp2d_pkg::S_DRAIN;
                end
            end
            mp2d_pkg::S_DRAIN: n_state = mp2d_pkg::S_DONE;
            default:           n_state = mp2d_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mp2d_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load     = accept && (i_operation == mp2d_pkg::OP_LOAD);
    assign o_cmd.capture  = accept && (i_operation == mp2d_pkg::OP_COMPUTE);
    assign o_cmd.issue    = (r_state == mp2d_pkg::S_WALK);
    assign o_result_valid = (r_state == mp2d_pkg::S_DONE);

endmodule

// ===== sv/mp2d_dpath.sv =====
// ----------------------------------------------------------------------------
// mp2d_dpath : plane store, tap address generation and running maximum
// One store read per tap; the read data is registered and folded into the
// running maximum in the following cycle.
// ----------------------------------------------------------------------------
module mp2d_dpath #(
    parameter int MAX_HEIGHT  = 64,
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mp2d_pkg::t_cmd                      i_cmd,
    input  mp2d_pkg::t_cfg                      i_cfg,
    input  logic [mp2d_pkg::COORD_BITS-1:0]     i_row,
    input  logic [mp2d_pkg::COORD_BITS-1:0]     i_col,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output mp2d_pkg::t_status                   o_status,
    output logic signed [SAMPLE_BITS-1:0]       o_max_value
);

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = mp2d_pkg::TAP_BITS;
    localparam int XW     = AW + CW;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    logic signed [CW-1:0]          r_base_r;
    logic signed [CW-1:0]          r_base_c;
    logic [KW-1:0]                 r_n;
    logic [KW-1:0]                 r_m;
    logic [KW-1:0]                 r_kh;
    logic [KW-1:0]                 r_kw;
    logic [HW-1:0]                 r_ph;
    logic [WW-1:0]                 r_pw;
    logic                          r_rd_valid;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_best;

    logic signed [CW-1:0]          tap_r;
    logic signed [CW-1:0]          tap_c;
    logic                          tap_valid;
    logic [XW-1:0]                 rd_addr_wide;
    logic [XW-1:0]                 wr_addr_wide;
    logic                          wr_in_store;
    logic                          m_wrap;

    // ---- store write (load item) ----
    assign wr_in_store  = (CW'(i_row) < CW'(MAX_HEIGHT)) && (CW'(i_col) < CW'(MAX_WIDTH));
    assign wr_addr_wide = XW'(i_row) * XW'(MAX_WIDTH) + XW'(i_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_in_store) begin
            mem[wr_addr_wide[AW-1:0]] <= i_sample;
        end
    end

    // ---- tap generation ----
    assign tap_r = r_base_r + $signed(CW'(r_n));
    assign tap_c = r_base_c + $signed(CW'(r_m));
    assign tap_valid = (r_n < r_kh) && (r_m < r_kw)
                    && !tap_r[CW-1] && (tap_r < $signed(CW'(r_ph)))
                    && !tap_c[CW-1] && (tap_c < $signed(CW'(r_pw)));
    assign rd_addr_wide = XW'(tap_r) * XW'(MAX_WIDTH) + XW'(tap_c);

    assign m_wrap            = (KW+1)'(r_m) + (KW+1)'(1) >= (KW+1)'(r_kw);
    assign o_status.last_tap = m_wrap && ((KW+1)'(r_n) + (KW+1)'(1) >= (KW+1)'(r_kh));

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr_wide[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_base_r <= $signed(CW'(i_row) * CW'(i_cfg.stride_rows)) - $signed(CW'(i_cfg.pad_top));
            r_base_c <= $signed(CW'(i_col) * CW'(i_cfg.stride_cols)) - $signed(CW'(i_cfg.pad_left));
            r_kh <= (CW'(i_cfg.kernel_height) > CW'(MAX_KERNEL)) ? KW'(MAX_KERNEL)
                                                                 : KW'(i_cfg.kernel_height);
            r_kw <= (CW'(i_cfg.kernel_width) > CW'(MAX_KERNEL)) ? KW'(MAX_KERNEL)
                                                                : KW'(i_cfg.kernel_width);
            r_ph <= (CW'(i_cfg.plane_height) > CW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                                : HW'(i_cfg.plane_height);
            r_pw <= (CW'(i_cfg.plane_width) > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                              : WW'(i_cfg.plane_width);
            r_n  <= '0;
            r_m  <= '0;
        end else if (i_cmd.issue) begin
            // advance column first, wrap into next row
            if (m_wrap) begin
                r_m <= '0;
                r_n <= r_n + KW'(1);
            end else begin
                r_m <= r_m + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue && tap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_best <= SAMPLE_MIN;
        end else if (r_rd_valid && (r_rd_data > r_best)) begin
            r_best <= r_rd_data;
        end
    end

    assign o_max_value = r_best;

endmodule

// ===== sv/max_pool_2d_window.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_window : 2-D max pooling over one stored feature-map plane
//
//   channel   direction  handshake                    payload
//   item      in         start & !busy                i_operation i_row i_col i_sample
//   result    out        o_result_valid (one cycle)   o_max_value
//   config    in         i_cfg_valid & o_cfg_ready    i_cfg_index i_cfg_data
//
// A load item writes the plane store and busy stays low. A compute item walks
// the window one plane-store read per tap, then drains the read pipe and
// strobes the result; busy covers the walk and the drain, and the next item
// is taken in the strobe cycle. kh and kw are clamped to MAX_KERNEL and a
// zero dimension is walked as one (an empty kernel still makes one walk step).
// The single store read port limits the walk to one tap read at a time. Reset
// is synchronous and active low; the store is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module max_pool_2d_window #(
    parameter int MAX_HEIGHT  = 64,
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [mp2d_pkg::COORD_BITS-1:0]     i_row,
    input  logic [mp2d_pkg::COORD_BITS-1:0]     i_col,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                o_result_valid,
    output logic signed [SAMPLE_BITS-1:0]       o_max_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    mp2d_pkg::t_cfg    cfg;
    mp2d_pkg::t_cmd    cmd;
    mp2d_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    mp2d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mp2d_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    mp2d_dpath #(
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_sample    (i_sample),
        .o_status    (status),
        .o_max_value (o_max_value)
    );

endmodule

// ===== sv/mp2d_checker.sv =====
// ----------------------------------------------------------------------------
// mp2d_checker : port-level checks for max_pool_2d_window
// Relates item beats, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module mp2d_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_operation,
    input logic o_result_valid
);

    // a compute beat always makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == mp2d_pkg::OP_COMPUTE)) |=> busy)
        else $error("compute beat did not raise busy");

    // a load beat never causes a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == mp2d_pkg::OP_LOAD)) |=> !o_result_valid)
        else $error("load beat produced a result");

    // result only at the end of a busy stretch
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy))
        else $error("result strobe without preceding busy");

    // end of busy always delivers a result
    a_busy_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result");

endmodule

bind max_pool_2d_window mp2d_checker u_mp2d_checker (.*);
